@@ hdl/swm_pkg.sv @@
// Package for the sliding window median block.
// Holds the sizing constants, the sequencer state type and the repair routine type; no dependencies.
`default_nettype none
package swm_pkg;
  localparam int unsigned WindowDefault = 16;
  localparam int unsigned SampleW = 16;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StLoad,
    StDispatch,
    StRdA,
    StRdB,
    StCmp,
    StSwap,
    StNext,
    StMed,
    StMedWait,
    StOut
  } seq_state_e;

  // Which repair routine runs: up or down on either heap.
  typedef enum logic [1:0] {
    OpMinUp,
    OpMaxUp,
    OpMinDown,
    OpMaxDown
  } op_e;
endpackage
`default_nettype wire

@@ hdl/swm_mem.sv @@
// Synchronous single-port-write, registered-read memory used for the sample
// and index tables of the sliding window median. No package dependency.
`default_nettype none
module swm_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/sliding_window_median.sv @@
// Sliding window running median over the last Window signed samples.
// Input beats arrive on sample_i/sample_valid_i, stalled by sample_stall_o;
// each accepted beat produces exactly one median beat on median_o with
// median_valid_o, which the receiver may hold off with median_stall_i.
// The window lives in a sample memory; heap-position and heap-slot tables
// in two more memories link slots and heap positions. A sequencer performs
// the sift steps one compare-exchange at a time. The old sample and its heap
// position are read at the accepting edge and used in the load state. Each
// compare step then runs through dispatch, two slot reads, two sample reads,
// compare with the first table write, and the second write. A step down that
// first picks between two children runs once more through the reads and the
// compare. Finding a routine already finished passes only through dispatch
// and the finishing state. The median read runs through the median state,
// the median-wait state and two output phases. One item is in flight at a
// time and sample_stall_o stays high while it is worked on. The median sits
// in an output register until taken; meanwhile the next beat may be accepted
// and sifted, and the sequencer waits before its median read while the
// receiver still stalls. After reset the sequencer sweeps the index tables
// with the fixed fill pattern, one entry a cycle, and accepts no beat until
// that sweep ends.
`default_nettype none
module sliding_window_median #(
  parameter int unsigned Window = swm_pkg::WindowDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] sample_i,
  input  wire logic        sample_valid_i,
  output logic             sample_stall_o,
  output logic      [15:0] median_o,
  output logic             median_valid_o,
  input  wire logic        median_stall_i
);
  localparam int unsigned HSize = Window + 1;
  localparam int unsigned SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned HAddrW = $clog2(HSize);
  localparam int unsigned PosW = HAddrW + 1; // signed heap position
  localparam int unsigned CntW = $clog2(Window / 2 + 1) + 1;
  localparam int unsigned Hoff = Window / 2;
  localparam int unsigned MinMax = (Window - 1) / 2;
  localparam int unsigned MaxMax = Window / 2;
  localparam int unsigned SW = swm_pkg::SampleW;

  typedef logic signed [PosW-1:0] pos_t;

  swm_pkg::seq_state_e state_q, state_d;
  swm_pkg::op_e op_q, op_d;

  logic [HAddrW-1:0] init_q, init_d;
  logic [SlotW-1:0]  oldest_q, oldest_d;
  logic [CntW-1:0]   minc_q, minc_d, maxc_q, maxc_d;
  pos_t              p_q, p_d;       // current position in sift
  pos_t              a_q, a_d, b_q, b_d; // pair under test: a below b swaps
  logic [SlotW-1:0]  sa_q, sa_d, sb_q, sb_d;
  logic signed [SW-1:0] va_q, va_d;
  logic signed [SW-1:0] new_q, new_d;
  logic [1:0]        phase_q, phase_d; // sub-phase of dispatch / median
  logic              sel_q, sel_d;   // down: choosing child
  logic [SW-1:0]     med_q, med_d;
  logic              ovalid_q, ovalid_d;

  // Memories.
  logic              smp_we;
  logic [SlotW-1:0]  smp_wa, smp_ra;
  logic [SW-1:0]     smp_wd;
  logic signed [SW-1:0] smp_rd;
  logic              pos_we;
  logic [SlotW-1:0]  pos_wa, pos_ra;
  logic signed [PosW-1:0] pos_wd, pos_rd;
  logic              hsi_we;
  logic [HAddrW-1:0] hsi_wa, hsi_ra;
  logic [SlotW-1:0]  hsi_wd, hsi_rd;

  swm_mem #(.Depth(Window), .Width(SW)) u_smp (
    .clk_i, .we_i(smp_we), .waddr_i(smp_wa), .wdata_i(smp_wd),
    .raddr_i(smp_ra), .rdata_o(smp_rd));
  swm_mem #(.Depth(Window), .Width(PosW)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_wa), .wdata_i(pos_wd),
    .raddr_i(pos_ra), .rdata_o(pos_rd));
  swm_mem #(.Depth(HSize), .Width(SlotW)) u_hsi (
    .clk_i, .we_i(hsi_we), .waddr_i(hsi_wa), .wdata_i(hsi_wd),
    .raddr_i(hsi_ra), .rdata_o(hsi_rd));

  function automatic logic [HAddrW-1:0] haddr(pos_t p);
    logic signed [PosW:0] k;
    k = PosW'(p) + (PosW+1)'(Hoff);
    return k[HAddrW-1:0];
  endfunction

  // Signed extended counts for comparisons.
  pos_t minc_s, maxc_s;
  assign minc_s = pos_t'({1'b0, minc_q});
  assign maxc_s = pos_t'({1'b0, maxc_q});

  // Init pattern: slot k -> (k+1)/2, negated for odd k.
  logic [HAddrW:0] init_half;
  pos_t init_pos;
  assign init_half = ({1'b0, init_q} + 1'b1) >> 1;
  assign init_pos = init_q[0] ? -pos_t'(init_half) : pos_t'(init_half);

  // Signed halving toward zero, as C does on positions.
  function automatic pos_t half(pos_t p);
    return (p < 0) ? -((-p) >>> 1) : (p >>> 1);
  endfunction

  logic signed [SW:0] msum;
  logic signed [SW:0] mhalf;
  assign msum = {va_q[SW-1], va_q} + {smp_rd[SW-1], smp_rd};
  assign mhalf = (msum < 0) ? -((-msum) >>> 1) : (msum >>> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm_pkg::StInit;
      op_q <= swm_pkg::OpMinUp;
      init_q <= '0;
      oldest_q <= '0;
      minc_q <= '0;
      maxc_q <= '0;
      phase_q <= '0;
      sel_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      init_q <= init_d;
      oldest_q <= oldest_d;
      minc_q <= minc_d;
      maxc_q <= maxc_d;
      phase_q <= phase_d;
      sel_q <= sel_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
    b_q <= b_d;
    sa_q <= sa_d;
    sb_q <= sb_d;
    va_q <= va_d;
    new_q <= new_d;
    med_q <= med_d;
  end

  // Phase codes for the dispatch chain.
  localparam logic [1:0] PhMain = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1; // post-up continuation
  localparam logic [1:0] PhMedZero = 2'd2;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    init_d = init_q;
    oldest_d = oldest_q;
    minc_d = minc_q;
    maxc_d = maxc_q;
    p_d = p_q;
    a_d = a_q;
    b_d = b_q;
    sa_d = sa_q;
    sb_d = sb_q;
    va_d = va_q;
    new_d = new_q;
    phase_d = phase_q;
    sel_d = sel_q;
    med_d = med_q;
    ovalid_d = ovalid_q;
    smp_we = 1'b0;
    smp_wa = oldest_q;
    smp_wd = new_q;
    smp_ra = oldest_q;
    pos_we = 1'b0;
    pos_wa = sa_q;
    pos_wd = b_q;
    pos_ra = oldest_q;
    hsi_we = 1'b0;
    hsi_wa = haddr(a_q);
    hsi_wd = sb_q;
    hsi_ra = haddr(a_q);
    sample_stall_o = 1'b1;

    if (ovalid_q && !median_stall_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      swm_pkg::StInit: begin
        pos_we = (init_q < HAddrW'(Window));
        pos_wa = init_q[SlotW-1:0];
        pos_wd = init_pos;
        hsi_we = pos_we;
        hsi_wa = haddr(init_pos);
        hsi_wd = init_q[SlotW-1:0];
        init_d = init_q + 1'b1;
        if (init_q == HAddrW'(Window - 1)) begin
          state_d = swm_pkg::StIdle;
        end
      end
      swm_pkg::StIdle: begin
        sample_stall_o = 1'b0;
        smp_ra = oldest_q;
        pos_ra = oldest_q;
        if (sample_valid_i) begin
          new_d = sample_i;
          state_d = swm_pkg::StLoad;
        end
      end
      swm_pkg::StLoad: begin
        // Old sample and heap position of the oldest slot are now read.
        p_d = pos_rd;
        smp_we = 1'b1;
        smp_wa = oldest_q;
        smp_wd = new_q;
        oldest_d = (oldest_q == SlotW'(Window - 1)) ? '0 : oldest_q + 1'b1;
        phase_d = PhMain;
        state_d = swm_pkg::StDispatch;
        if (pos_rd > 0) begin
          if (minc_q < CntW'(MinMax)) begin
            minc_d = minc_q + 1'b1;
            op_d = swm_pkg::OpMinUp;
          end else if (new_q > smp_rd) begin
            op_d = swm_pkg::OpMinDown;
            p_d = pos_rd <<< 1;
          end else begin
            op_d = swm_pkg::OpMinUp;
          end
        end else if (pos_rd < 0) begin
          if (maxc_q < CntW'(MaxMax)) begin
            maxc_d = maxc_q + 1'b1;
            op_d = swm_pkg::OpMaxUp;
          end else if (new_q < smp_rd) begin
            op_d = swm_pkg::OpMaxDown;
            p_d = pos_rd <<< 1;
          end else begin
            op_d = swm_pkg::OpMaxUp;
          end
        end else begin
          phase_d = PhMedZero;
          op_d = swm_pkg::OpMaxUp;
          p_d = -pos_t'(1);
          if (maxc_q == '0) begin
            op_d = swm_pkg::OpMinUp;
            p_d = pos_t'(1);
            if (minc_q == '0) state_d = swm_pkg::StMed;
          end
        end
      end
      swm_pkg::StDispatch: begin
        // Set up the next compare for the current operation.
        sel_d = 1'b0;
        unique case (op_q)
          swm_pkg::OpMinUp: begin
            a_d = p_q;
            b_d = half(p_q);
            if (p_q <= 0) state_d = swm_pkg::StNext;
            else state_d = swm_pkg::StRdA;
          end
          swm_pkg::OpMaxUp: begin
            a_d = half(p_q);
            b_d = p_q;
            if (p_q >= 0) state_d = swm_pkg::StNext;
            else state_d = swm_pkg::StRdA;
          end
          swm_pkg::OpMinDown: begin
            // p_q is the child index already doubled.
            if (p_q > minc_s) begin
              state_d = swm_pkg::StNext;
            end else if (p_q < minc_s) begin
              sel_d = 1'b1;
              a_d = p_q + pos_t'(1);
              b_d = p_q;
              state_d = swm_pkg::StRdA;
            end else begin
              a_d = p_q;
              b_d = half(p_q);
              state_d = swm_pkg::StRdA;
            end
          end
          default: begin
            if (p_q < -maxc_s) begin
              state_d = swm_pkg::StNext;
            end else if (p_q > -maxc_s) begin
              sel_d = 1'b1;
              a_d = p_q;
              b_d = p_q - pos_t'(1);
              state_d = swm_pkg::StRdA;
            end else begin
              a_d = half(p_q);
              b_d = p_q;
              state_d = swm_pkg::StRdA;
            end
          end
        endcase
      end
      swm_pkg::StRdA: begin
        hsi_ra = haddr(a_q);
        state_d = swm_pkg::StRdB;
        phase_d = phase_q;
      end
      swm_pkg::StRdB: begin
        hsi_ra = haddr(b_q);
        sa_d = hsi_rd;
        smp_ra = hsi_rd;
        state_d = swm_pkg::StCmp;
      end
      swm_pkg::StCmp: begin
        sb_d = hsi_rd;
        va_d = smp_rd;
        smp_ra = hsi_rd;
        state_d = swm_pkg::StSwap;
      end
      swm_pkg::StSwap: begin
        if (sel_q) begin
          // Child choice: pick the better sibling, then compare with parent.
          sel_d = 1'b0;
          state_d = swm_pkg::StRdA;
          if (op_q == swm_pkg::OpMinDown) begin
            p_d = (va_q < smp_rd) ? a_q : b_q;
            a_d = (va_q < smp_rd) ? a_q : b_q;
            b_d = half((va_q < smp_rd) ? a_q : b_q);
          end else begin
            p_d = (va_q < smp_rd) ? b_q : a_q;
            a_d = half((va_q < smp_rd) ? b_q : a_q);
            b_d = (va_q < smp_rd) ? b_q : a_q;
          end
        end else if (va_q < smp_rd) begin
          // First half of the swap: move slot b to position a and fix its back link.
          hsi_we = 1'b1;
          hsi_wa = haddr(a_q);
          hsi_wd = sb_q;
          pos_we = 1'b1;
          pos_wa = sb_q;
          pos_wd = a_q;
          state_d = swm_pkg::StNext;
          sel_d = 1'b1;
        end else begin
          // No exchange: this routine stops here.
          p_d = (op_q == swm_pkg::OpMinUp || op_q == swm_pkg::OpMaxUp) ?
                pos_t'(1) : p_q;
          sel_d = 1'b0;
          a_d = pos_t'(1);
          state_d = swm_pkg::StNext;
          phase_d = phase_q;
        end
      end
      swm_pkg::StNext: begin
        if (sel_q) begin
          // Second half of a swap, then advance.
          hsi_we = 1'b1;
          hsi_wa = haddr(b_q);
          hsi_wd = sa_q;
          pos_we = 1'b1;
          pos_wa = sa_q;
          pos_wd = b_q;
          sel_d = 1'b0;
          state_d = swm_pkg::StDispatch;
          unique case (op_q)
            swm_pkg::OpMinUp: p_d = b_q;
            swm_pkg::OpMaxUp: p_d = a_q;
            swm_pkg::OpMinDown: p_d = a_q <<< 1;
            default: p_d = b_q <<< 1;
          endcase
          // A swap at the median boundary is the tail pair step.
          if (phase_q == PhSecond) begin
            phase_d = PhMain;
            state_d = swm_pkg::StDispatch;
            op_d = (op_q == swm_pkg::OpMinUp) ? swm_pkg::OpMaxDown
                                              : swm_pkg::OpMinDown;
            p_d = (op_q == swm_pkg::OpMinUp) ? -pos_t'(2) : pos_t'(2);
          end
        end else begin
          // Routine finished; p_q == 0 means an up sift reached the top.
          state_d = swm_pkg::StMed;
          unique case (op_q)
            swm_pkg::OpMinUp: begin
              if (phase_q == PhMedZero) begin
                if (p_q == 0) begin
                  op_d = swm_pkg::OpMinDown;
                  p_d = pos_t'(2);
                  phase_d = PhMain;
                  state_d = swm_pkg::StDispatch;
                end
              end else if (phase_q == PhMain && p_q == 0) begin
                phase_d = PhSecond;
                a_d = pos_t'(0);
                b_d = -pos_t'(1);
                state_d = swm_pkg::StRdA;
              end
            end
            swm_pkg::OpMaxUp: begin
              if (phase_q == PhMedZero) begin
                if (p_q == 0) begin
                  op_d = swm_pkg::OpMaxDown;
                  p_d = -pos_t'(2);
                  phase_d = PhMedZero;
                  state_d = swm_pkg::StDispatch;
                end else if (minc_q != '0) begin
                  op_d = swm_pkg::OpMinUp;
                  p_d = pos_t'(1);
                  state_d = swm_pkg::StDispatch;
                end
              end else if (phase_q == PhMain && p_q == 0 && minc_q != '0) begin
                phase_d = PhSecond;
                a_d = pos_t'(1);
                b_d = pos_t'(0);
                state_d = swm_pkg::StRdA;
              end
            end
            swm_pkg::OpMaxDown: begin
              if (phase_q == PhMedZero && minc_q != '0) begin
                op_d = swm_pkg::OpMinUp;
                p_d = pos_t'(1);
                state_d = swm_pkg::StDispatch;
              end
            end
            default: begin
            end
          endcase
          if (phase_q == PhSecond) begin
            // Boundary pair was in order: done.
            state_d = swm_pkg::StMed;
          end
        end
      end
      swm_pkg::StMed: begin
        hsi_ra = haddr(pos_t'(0));
        phase_d = PhMain;
        // The median read starts only once the output register is free.
        if (!ovalid_q || !median_stall_i) begin
          state_d = swm_pkg::StMedWait;
        end
      end
      swm_pkg::StMedWait: begin
        smp_ra = hsi_rd;
        hsi_ra = haddr(-pos_t'(1));
        state_d = swm_pkg::StOut;
        phase_d = PhMain;
      end
      swm_pkg::StOut: begin
        if (phase_q == PhMain) begin
          va_d = smp_rd;
          smp_ra = hsi_rd;
          phase_d = PhSecond;
        end else begin
          med_d = (minc_q < maxc_q) ? mhalf[SW-1:0] : va_q;
          ovalid_d = 1'b1;
          state_d = swm_pkg::StIdle;
        end
      end
      default: state_d = swm_pkg::StIdle;
    endcase
  end

  assign median_o = med_q;
  assign median_valid_o = ovalid_q;
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the sliding window median block: directed and random sample
// beats, a running-median predictor and a result checker. Depends on swm_pkg.
`default_nettype none
module tb_top;
  localparam int Win = swm_pkg::WindowDefault;
  localparam int HalfWin = Win / 2;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [15:0] sample_i = '0;
  logic sample_valid_i = 1'b0;
  logic sample_stall_o;
  logic [15:0] median_o;
  logic median_valid_o;
  logic median_stall_i = 1'b0;

  sliding_window_median i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state: the window, the two link tables and the heap counts.
  int win_val [Win];
  int slot_pos [Win];
  int pos_slot [Win + 1];
  int min_cnt, max_cnt, next_slot;

  logic [15:0] median_queue [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  function automatic int slot_of(int p);
    return pos_slot[p + HalfWin];
  endfunction

  function automatic int val_of(int p);
    return win_val[slot_of(p)];
  endfunction

  function automatic bit lower(int a, int b);
    return val_of(a) < val_of(b);
  endfunction

  function automatic void exchange(int a, int b);
    int t;
    t = pos_slot[a + HalfWin];
    pos_slot[a + HalfWin] = pos_slot[b + HalfWin];
    pos_slot[b + HalfWin] = t;
    slot_pos[slot_of(a)] = a;
    slot_pos[slot_of(b)] = b;
  endfunction

  function automatic bit fix_pair(int a, int b);
    if (!lower(a, b)) return 1'b0;
    exchange(a, b);
    return 1'b1;
  endfunction

  function automatic void sink_min(int p);
    for (p = p * 2; p <= min_cnt; p = p * 2) begin
      if (p < min_cnt && lower(p + 1, p)) p++;
      if (!fix_pair(p, p / 2)) break;
    end
  endfunction

  function automatic void sink_max(int p);
    for (p = p * 2; p >= -max_cnt; p = p * 2) begin
      if (p > -max_cnt && lower(p, p - 1)) p--;
      if (!fix_pair(p / 2, p)) break;
    end
  endfunction

  function automatic bit rise_min(int p);
    while (p > 0 && fix_pair(p, p / 2)) p = p / 2;
    return p == 0;
  endfunction

  function automatic bit rise_max(int p);
    while (p < 0 && fix_pair(p / 2, p)) p = p / 2;
    return p == 0;
  endfunction

  function automatic void reset_window();
    int p;
    min_cnt = 0;
    max_cnt = 0;
    next_slot = 0;
    for (int k = 0; k < Win; k++) begin
      win_val[k] = 0;
      p = (k + 1) / 2;
      if (k & 1) p = -p;
      slot_pos[k] = p;
      pos_slot[p + HalfWin] = k;
    end
  endfunction

  // Inserts one sample and returns the running median.
  function automatic logic [15:0] insert_median(logic signed [15:0] s);
    int v, slot, old, med, p;
    bit grow;
    v = s;
    slot = next_slot;
    p = slot_pos[slot];
    old = win_val[slot];
    win_val[slot] = v;
    next_slot = (slot + 1) % Win;
    if (p > 0) begin
      grow = min_cnt < (Win - 1) / 2;
      if (grow) min_cnt++;
      if (!grow && v > old) sink_min(p);
      else if (rise_min(p) && fix_pair(0, -1)) sink_max(-1);
    end else if (p < 0) begin
      grow = max_cnt < HalfWin;
      if (grow) max_cnt++;
      if (!grow && v < old) sink_max(p);
      else if (rise_max(p) && min_cnt != 0 && fix_pair(1, 0)) sink_min(1);
    end else begin
      if (max_cnt != 0 && rise_max(-1)) sink_max(-1);
      if (min_cnt != 0 && rise_min(1)) sink_min(1);
    end
    med = val_of(0);
    if (min_cnt < max_cnt) med = (med + val_of(-1)) / 2;
    return med[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch: %s got %0d expected %0d", what, $signed(got), $signed(want));
    fail_count++;
  endtask

  // Valid stays high after a beat; drain(), or an idle gap drawn in the next call, takes it down.
  task automatic send_sample(logic [15:0] s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    sample_i <= s;
    sample_valid_i <= 1'b1;
    do @(posedge clk_i); while (sample_stall_o);
    median_queue.push_back(insert_median(s));
    @(negedge clk_i);
  endtask

  task automatic drain();
    sample_valid_i <= 1'b0;
    while (median_queue.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stall, redrawn at every falling edge.
  always @(negedge clk_i) begin
    median_stall_i <= long_hold ||
                      (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && median_valid_o && !median_stall_i) begin
      if (median_queue.size() == 0) begin
        report_mismatch("unexpected median beat", median_o, '0);
      end else begin
        logic [15:0] want;
        want = median_queue.pop_front();
        if (median_o !== want) report_mismatch("median", median_o, want);
      end
    end
  end

  // Watchdog on cycles with neither an accepted sample beat nor a taken median beat.
  always @(posedge clk_i) begin
    if ((sample_valid_i && !sample_stall_o) || (median_valid_o && !median_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("** sliding_window_median: FAILED **");
      $finish;
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'(16'h8000 + $urandom_range(3));
      1: return 16'(16'h7fff - $urandom_range(3));
      2: return 16'($urandom_range(8) - 4);
      3: return 16'($urandom_range(31));
      default: return 16'($urandom());
    endcase
  endfunction

  // Extremes, repeats, window filling and alternating wrap-around values.
  task automatic test_directed();
    logic [15:0] dir [$];
    dir = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h0001,
            16'h5555, 16'haaaa, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000,
            16'hfffe, 16'h0002, 16'h1234, 16'hedcb, 16'h7fff, 16'h8000, 16'h0000};
    foreach (dir[i]) send_sample(dir[i]);
    drain();
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) send_sample(rand_sample());
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Sorted runs push the sift paths to full depth; a constant run follows.
  task automatic test_ramps();
    for (int i = 0; i < 40; i++) send_sample(16'(16'h8000 + i * 1600));
    for (int i = 0; i < 40; i++) send_sample(16'(16'h7fff - i * 1600));
    repeat (20) send_sample(16'h0101);
    drain();
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      repeat (10) send_sample(rand_sample());
    join
    drain();
  endtask

  initial begin
    reset_window();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(120, 0, 0);
    test_ramps();
    test_random(100, 74, 0);
    test_random(100, 0, 74);
    test_backpressure();
    test_random(100, 15, 15);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && median_queue.size() == 0)
      $display("** sliding_window_median: PASSED **");
    else
      $display("** sliding_window_median: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
